// ----- sv/fasta_index_scanner_unit_assert.svh -----
// assertion helpers for the scanner core
`ifndef FASTA_INDEX_SCANNER_UNIT_ASSERT_SVH
`define FASTA_INDEX_SCANNER_UNIT_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define FIS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define FIS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/fis_pkg.sv -----
package fis_pkg;

   localparam int REC_OFFSET_W = 40;
   localparam int LINE_W       = 32;

   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_EOS  = 1'b1;

   localparam logic KIND_NAME   = 1'b0;
   localparam logic KIND_RECORD = 1'b1;

   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic                    kind;
      logic [7:0]              name_byte;
      logic [REC_OFFSET_W-1:0] seq_length;
      logic [REC_OFFSET_W-1:0] seq_start_offset;
      logic [LINE_W-1:0]       bases_per_line;
      logic [LINE_W-1:0]       bytes_per_line;
   } result_type;

endpackage

// ----- sv/fis_in_stage.sv -----
module fis_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fis_pkg::item_type req_item,
   output logic              item_valid,
   output fis_pkg::item_type item,
   input  logic              item_take
);

   logic              valid_ff, valid_in;
   fis_pkg::item_type item_ff, item_in;

   assign req_ready = !valid_ff || item_take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_ready) begin
         valid_in = req_valid;
         item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- sv/fis_core.sv -----
`include "fasta_index_scanner_unit_assert.svh"

module fis_core #(
   parameter int MAX_NAME_BYTES = 255,
   parameter int OFFSET_BITS    = 40
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  fis_pkg::item_type   item,
   output logic                item_take,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fis_pkg::result_type rsp_result
);

   localparam int LW = fis_pkg::LINE_W;

   logic [OFFSET_BITS-1:0] byte_offset_ff, byte_offset_in;
   logic                   in_sequence_ff, in_sequence_in;
   logic                   in_header_ff, in_header_in;
   logic                   at_line_start_ff, at_line_start_in;
   logic                   blank_ff, blank_in;
   logic                   copying_ff, copying_in;
   logic [7:0]             name_count_ff, name_count_in;
   logic [OFFSET_BITS-1:0] base_total_ff, base_total_in;
   logic [OFFSET_BITS-1:0] start_offset_ff, start_offset_in;
   logic [LW-1:0]          first_bases_ff, first_bases_in;
   logic [LW-1:0]          first_bytes_ff, first_bytes_in;
   logic [LW-1:0]          line_bases_ff, line_bases_in;
   logic [LW-1:0]          line_bytes_ff, line_bytes_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   fis_pkg::result_type    result_ff, result_in;

   logic                   advance;
   logic [7:0]             b;
   logic                   is_lf, is_cr, is_sep;
   logic                   eff_header, eff_blank;
   logic [LW-1:0]          eff_bases, eff_bytes, new_bases, new_bytes;
   logic [LW-1:0]          commit_bases, commit_bytes;
   logic [OFFSET_BITS:0]   commit_sum;
   logic [OFFSET_BITS-1:0] commit_total;
   logic                   record_due;
   logic                   name_emit;

   logic                   eos_take, lf_take, scan_idle, name_out;
   logic [7:0]             name_count_up;

   function automatic logic [fis_pkg::REC_OFFSET_W-1:0] to_rec(
      input logic [OFFSET_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[fis_pkg::REC_OFFSET_W-1:0];
   endfunction

   function automatic logic [LW-1:0] inc32(input logic [LW-1:0] v);
      return (&v) ? v : v + LW'(1);
   endfunction

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign item_take = item_valid && advance;

   assign b      = item.data_byte;
   assign is_lf  = (b == fis_pkg::CHAR_LF);
   assign is_cr  = (b == fis_pkg::CHAR_CR);
   assign is_sep = is_lf || (b == fis_pkg::CHAR_SPACE) || (b == fis_pkg::CHAR_TAB);

   // per-line view once the line start has been resolved
   assign eff_header = at_line_start_ff ? 1'b0 : in_header_ff;
   assign eff_blank  = at_line_start_ff ? !(in_sequence_ff && !is_lf && !is_cr) : blank_ff;
   assign eff_bases  = at_line_start_ff ? '0 : line_bases_ff;
   assign eff_bytes  = at_line_start_ff ? '0 : line_bytes_ff;
   assign new_bytes  = inc32(eff_bytes);
   assign new_bases  = (is_lf || is_cr) ? eff_bases : inc32(eff_bases);

   // one shared saturating adder for closing a data line
   assign commit_bases = (item.command == fis_pkg::CMD_EOS) ? line_bases_ff : new_bases;
   assign commit_bytes = (item.command == fis_pkg::CMD_EOS) ? line_bytes_ff : new_bytes;
   assign commit_sum   = {1'b0, base_total_ff} + (OFFSET_BITS + 1)'(commit_bases);
   assign commit_total = commit_sum[OFFSET_BITS] ? '1 : commit_sum[OFFSET_BITS-1:0];

   assign record_due = in_sequence_ff && (name_count_ff != 8'd0);
   assign name_emit  = item_take && (item.command == fis_pkg::CMD_DATA) && eff_header
                       && copying_ff && !is_sep
                       && (name_count_ff < 8'(MAX_NAME_BYTES));

   always_comb begin
      byte_offset_in   = byte_offset_ff;
      in_sequence_in   = in_sequence_ff;
      in_header_in     = in_header_ff;
      at_line_start_in = at_line_start_ff;
      blank_in         = blank_ff;
      copying_in       = copying_ff;
      name_count_in    = name_count_ff;
      base_total_in    = base_total_ff;
      start_offset_in  = start_offset_ff;
      first_bases_in   = first_bases_ff;
      first_bytes_in   = first_bytes_ff;
      line_bases_in    = line_bases_ff;
      line_bytes_in    = line_bytes_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      result_in    = result_ff;

      if (item_take) begin
         if (item.command == fis_pkg::CMD_EOS) begin
            // close an unterminated last line, then flush
            if (!at_line_start_ff) begin
               if (in_header_ff) begin
                  start_offset_in = byte_offset_ff;
               end else if (!blank_ff) begin
                  base_total_in = commit_total;
                  if (first_bases_ff == '0) begin
                     first_bases_in = commit_bases;
                     first_bytes_in = commit_bytes;
                  end
               end
            end
            if (record_due) begin
               rsp_valid_in                = 1'b1;
               result_in.kind              = fis_pkg::KIND_RECORD;
               result_in.name_byte         = 8'd0;
               result_in.seq_length        = to_rec(base_total_in);
               result_in.seq_start_offset  = to_rec(start_offset_in);
               result_in.bases_per_line    = first_bases_in;
               result_in.bytes_per_line    = first_bytes_in;
            end
            byte_offset_in   = '0;
            in_sequence_in   = 1'b0;
            in_header_in     = 1'b0;
            at_line_start_in = 1'b1;
            blank_in         = 1'b0;
            copying_in       = 1'b0;
            name_count_in    = 8'd0;
            base_total_in    = '0;
            start_offset_in  = '0;
            first_bases_in   = '0;
            first_bytes_in   = '0;
            line_bases_in    = '0;
            line_bytes_in    = '0;
         end else begin
            byte_offset_in   = (&byte_offset_ff) ? byte_offset_ff
                               : byte_offset_ff + OFFSET_BITS'(1);
            at_line_start_in = 1'b0;
            if (at_line_start_ff && (b == fis_pkg::CHAR_GT)) begin
               if (record_due) begin
                  rsp_valid_in                = 1'b1;
                  result_in.kind              = fis_pkg::KIND_RECORD;
                  result_in.name_byte         = 8'd0;
                  result_in.seq_length        = to_rec(base_total_ff);
                  result_in.seq_start_offset  = to_rec(start_offset_ff);
                  result_in.bases_per_line    = first_bases_ff;
                  result_in.bytes_per_line    = first_bytes_ff;
               end
               in_sequence_in  = 1'b1;
               in_header_in    = 1'b1;
               blank_in        = 1'b0;
               copying_in      = 1'b1;
               name_count_in   = 8'd0;
               base_total_in   = '0;
               start_offset_in = '0;
               first_bases_in  = '0;
               first_bytes_in  = '0;
            end else begin
               if (at_line_start_ff) begin
                  in_header_in  = 1'b0;
                  blank_in      = eff_blank;
                  line_bases_in = '0;
                  line_bytes_in = '0;
               end
               if (eff_header) begin
                  if (copying_ff && is_sep) begin
                     copying_in = 1'b0;
                  end
                  if (name_emit) begin
                     rsp_valid_in                = 1'b1;
                     result_in.kind              = fis_pkg::KIND_NAME;
                     result_in.name_byte         = b;
                     result_in.seq_length        = '0;
                     result_in.seq_start_offset  = '0;
                     result_in.bases_per_line    = '0;
                     result_in.bytes_per_line    = '0;
                     name_count_in               = name_count_ff + 8'd1;
                  end
                  if (is_lf) begin
                     start_offset_in  = byte_offset_in;
                     in_header_in     = 1'b0;
                     copying_in       = 1'b0;
                     at_line_start_in = 1'b1;
                  end
               end else if (!eff_blank) begin
                  line_bytes_in = new_bytes;
                  line_bases_in = new_bases;
                  if (is_lf) begin
                     base_total_in = commit_total;
                     if (first_bases_ff == '0) begin
                        first_bases_in = commit_bases;
                        first_bytes_in = commit_bytes;
                     end
                     at_line_start_in = 1'b1;
                  end
               end else if (is_lf) begin
                  at_line_start_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff   <= '0;
         in_sequence_ff   <= 1'b0;
         in_header_ff     <= 1'b0;
         at_line_start_ff <= 1'b1;
         blank_ff         <= 1'b0;
         copying_ff       <= 1'b0;
         name_count_ff    <= 8'd0;
         base_total_ff    <= '0;
         start_offset_ff  <= '0;
         first_bases_ff   <= '0;
         first_bytes_ff   <= '0;
         line_bases_ff    <= '0;
         line_bytes_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         byte_offset_ff   <= byte_offset_in;
         in_sequence_ff   <= in_sequence_in;
         in_header_ff     <= in_header_in;
         at_line_start_ff <= at_line_start_in;
         blank_ff         <= blank_in;
         copying_ff       <= copying_in;
         name_count_ff    <= name_count_in;
         base_total_ff    <= base_total_in;
         start_offset_ff  <= start_offset_in;
         first_bases_ff   <= first_bases_in;
         first_bytes_ff   <= first_bytes_in;
         line_bases_ff    <= line_bases_in;
         line_bytes_ff    <= line_bytes_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

   assign eos_take      = item_take && (item.command == fis_pkg::CMD_EOS);
   assign lf_take       = item_take && (item.command == fis_pkg::CMD_DATA) && is_lf;
   assign scan_idle     = at_line_start_ff && !in_sequence_ff && (name_count_ff == 8'd0);
   assign name_out      = rsp_valid_ff && (result_ff.kind == fis_pkg::KIND_NAME);
   assign name_count_up = name_count_ff + 8'd1;

   `FIS_ASSERT_NEXT(a_eos_clears, clock, reset, eos_take, scan_idle)
   `FIS_ASSERT_NEXT(a_name_out, clock, reset, name_emit, name_out)
   `FIS_ASSERT_NEXT(a_name_inc, clock, reset, name_emit, name_count_ff == $past(name_count_up))
   `FIS_ASSERT_NEXT(a_lf_ends_line, clock, reset, lf_take, at_line_start_ff)
   `FIS_ASSERT_NOW(a_name_bound, clock, reset, 1'b1, name_count_ff <= 8'(MAX_NAME_BYTES))

endmodule

// ----- sv/fasta_index_scanner_unit.sv -----
// channel | dir | fields
// req     | in  | command, data_byte
// rsp     | out | kind, name_byte, seq_length, seq_start_offset, bases_per_line, bytes_per_line
//
// one item per cycle sustained while no result waits; the input register feeds the scan
// logic, whose result register drives the rsp channel, so each result passes through the
// input register and then the result register after its item is accepted
// synchronous active-high reset returns the scanner to the start of a new file
// a waiting result holds the scan stage and drops req_ready in the same cycle once the
// input register is full; the input register still takes one more item

module fasta_index_scanner_unit #(
   parameter int MAX_NAME_BYTES = 255,
   parameter int OFFSET_BITS    = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_name_byte,
   output logic [39:0] rsp_seq_length,
   output logic [39:0] rsp_seq_start_offset,
   output logic [31:0] rsp_bases_per_line,
   output logic [31:0] rsp_bytes_per_line
);

   fis_pkg::item_type   req_item;
   fis_pkg::item_type   item;
   logic                item_valid;
   logic                item_take;
   fis_pkg::result_type result;

   assign req_item.command   = req_command;
   assign req_item.data_byte = req_data_byte;

   fis_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   fis_core #(
      .MAX_NAME_BYTES (MAX_NAME_BYTES),
      .OFFSET_BITS    (OFFSET_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (result)
   );

   assign rsp_kind             = result.kind;
   assign rsp_name_byte        = result.name_byte;
   assign rsp_seq_length       = result.seq_length;
   assign rsp_seq_start_offset = result.seq_start_offset;
   assign rsp_bases_per_line   = result.bases_per_line;
   assign rsp_bytes_per_line   = result.bytes_per_line;

endmodule

// ----- tb/fasta_index_scanner_checker.sv -----
module fasta_index_scanner_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_kind,
   input  logic [7:0]  rsp_name_byte,
   input  logic [39:0] rsp_seq_length,
   input  logic [39:0] rsp_seq_start_offset,
   input  logic [31:0] rsp_bases_per_line,
   input  logic [31:0] rsp_bytes_per_line,
   output int          fail_count,
   output int          outstanding
);

   localparam logic [39:0] POS_MAX      = '1;
   localparam logic [31:0] LINE_MAX     = '1;
   localparam int          NAME_LIMIT   = 255;
   localparam int          REPORT_LIMIT = 10;

   fis_pkg::result_type expected_entries[$];

   logic [39:0] file_pos;
   logic [39:0] base_sum;
   logic [39:0] hdr_end_pos;
   logic [31:0] first_bases;
   logic [31:0] first_bytes;
   logic [31:0] cur_bases;
   logic [31:0] cur_bytes;
   logic [7:0]  name_bytes;
   bit          seq_open;
   bit          header_line;
   bit          line_start;
   bit          skip_line;
   bit          name_copy;

   function automatic void clear_scan();
      file_pos    = '0;
      seq_open    = 1'b0;
      header_line = 1'b0;
      line_start  = 1'b1;
      skip_line   = 1'b0;
      name_copy   = 1'b0;
      name_bytes  = '0;
      base_sum    = '0;
      hdr_end_pos = '0;
      first_bases = '0;
      first_bytes = '0;
      cur_bases   = '0;
      cur_bytes   = '0;
   endfunction

   function automatic void add_line_to_total();
      logic [40:0] sum;
      sum = {1'b0, base_sum} + {9'b0, cur_bases};
      base_sum = sum[40] ? POS_MAX : sum[39:0];
      if (first_bases == '0) begin
         first_bases = cur_bases;
         first_bytes = cur_bytes;
      end
   endfunction

   // record for the sequence just closed, if it had a name
   function automatic void close_sequence();
      fis_pkg::result_type rec;
      if (seq_open && name_bytes != '0) begin
         rec.kind             = fis_pkg::KIND_RECORD;
         rec.name_byte        = '0;
         rec.seq_length       = base_sum;
         rec.seq_start_offset = hdr_end_pos;
         rec.bases_per_line   = first_bases;
         rec.bytes_per_line   = first_bytes;
         expected_entries.push_back(rec);
      end
   endfunction

   function automatic void scan_fasta_item(logic cmd, logic [7:0] b);
      fis_pkg::result_type nb;
      if (cmd == fis_pkg::CMD_EOS) begin
         // an unterminated last line still counts as a whole line
         if (!line_start) begin
            if (header_line)
               hdr_end_pos = file_pos;
            else if (!skip_line)
               add_line_to_total();
         end
         close_sequence();
         clear_scan();
      end else begin
         file_pos = (file_pos == POS_MAX) ? file_pos : file_pos + 1'b1;
         if (line_start && b == fis_pkg::CHAR_GT) begin
            line_start = 1'b0;
            close_sequence();
            seq_open    = 1'b1;
            header_line = 1'b1;
            skip_line   = 1'b0;
            name_copy   = 1'b1;
            name_bytes  = '0;
            base_sum    = '0;
            hdr_end_pos = '0;
            first_bases = '0;
            first_bytes = '0;
         end else begin
            if (line_start) begin
               line_start  = 1'b0;
               header_line = 1'b0;
               skip_line   = !(seq_open && b != fis_pkg::CHAR_LF && b != fis_pkg::CHAR_CR);
               cur_bases   = '0;
               cur_bytes   = '0;
            end
            if (header_line) begin
               if (name_copy) begin
                  if (b == fis_pkg::CHAR_SPACE || b == fis_pkg::CHAR_TAB ||
                      b == fis_pkg::CHAR_LF) begin
                     name_copy = 1'b0;
                  end else if (name_bytes < NAME_LIMIT) begin
                     nb = '0;
                     nb.kind      = fis_pkg::KIND_NAME;
                     nb.name_byte = b;
                     expected_entries.push_back(nb);
                     name_bytes++;
                  end
               end
               if (b == fis_pkg::CHAR_LF) begin
                  hdr_end_pos = file_pos;
                  header_line = 1'b0;
                  name_copy   = 1'b0;
                  line_start  = 1'b1;
               end
            end else if (!skip_line) begin
               cur_bytes = (cur_bytes == LINE_MAX) ? cur_bytes : cur_bytes + 1'b1;
               if (b != fis_pkg::CHAR_LF && b != fis_pkg::CHAR_CR)
                  cur_bases = (cur_bases == LINE_MAX) ? cur_bases : cur_bases + 1'b1;
               if (b == fis_pkg::CHAR_LF) begin
                  add_line_to_total();
                  line_start = 1'b1;
               end
            end else if (b == fis_pkg::CHAR_LF) begin
               line_start = 1'b1;
            end
         end
      end
   endfunction

   always @(posedge clock) begin : watch_channels
      fis_pkg::result_type got;
      fis_pkg::result_type want;
      bit                  bad;
      if (reset) begin
         clear_scan();
         expected_entries.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            scan_fasta_item(req_command, req_data_byte);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_kind, rsp_name_byte, rsp_seq_length, rsp_seq_start_offset,
                   rsp_bases_per_line, rsp_bytes_per_line};
            if (expected_entries.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display({"unexpected result: kind %0d name %02h len %0d off %0d",
                            " bpl %0d Bpl %0d"},
                           got.kind, got.name_byte, got.seq_length, got.seq_start_offset,
                           got.bases_per_line, got.bytes_per_line);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_entries.pop_front();
               bad  = (got.kind !== want.kind) || (got.name_byte !== want.name_byte) ||
                      (got.seq_length !== want.seq_length) ||
                      (got.seq_start_offset !== want.seq_start_offset) ||
                      (got.bases_per_line !== want.bases_per_line) ||
                      (got.bytes_per_line !== want.bytes_per_line);
               if (bad) begin
                  if (fail_count < REPORT_LIMIT)
                     $display({"result mismatch: expected kind %0d name %02h len %0d off %0d",
                               " bpl %0d Bpl %0d, got kind %0d name %02h len %0d off %0d",
                               " bpl %0d Bpl %0d"},
                              want.kind, want.name_byte, want.seq_length,
                              want.seq_start_offset, want.bases_per_line, want.bytes_per_line,
                              got.kind, got.name_byte, got.seq_length,
                              got.seq_start_offset, got.bases_per_line, got.bytes_per_line);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      outstanding <= expected_entries.size();
   end

endmodule

// ----- tb/fasta_index_scanner_unit_test.sv -----
module fasta_index_scanner_unit_test;

   localparam int ITEM_TARGET  = 1700;
   localparam int QUIET_LIMIT  = 200;
   localparam int DRAIN_CYCLES = 10;

   // line end kinds
   localparam int TERM_LF   = 0;
   localparam int TERM_CRLF = 1;
   localparam int TERM_NONE = 2;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_command   = fis_pkg::CMD_DATA;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_ready     = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic        rsp_kind;
   logic [7:0]  rsp_name_byte;
   logic [39:0] rsp_seq_length;
   logic [39:0] rsp_seq_start_offset;
   logic [31:0] rsp_bases_per_line;
   logic [31:0] rsp_bytes_per_line;

   int fail_count;
   int outstanding;
   int items_sent  = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   string base_chars = "ACGTNacgtn";

   always #5 clock = ~clock;

   fasta_index_scanner_unit u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_data_byte        (req_data_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_name_byte        (rsp_name_byte),
      .rsp_seq_length       (rsp_seq_length),
      .rsp_seq_start_offset (rsp_seq_start_offset),
      .rsp_bases_per_line   (rsp_bases_per_line),
      .rsp_bytes_per_line   (rsp_bytes_per_line)
   );

   fasta_index_scanner_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_data_byte        (req_data_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_name_byte        (rsp_name_byte),
      .rsp_seq_length       (rsp_seq_length),
      .rsp_seq_start_offset (rsp_seq_start_offset),
      .rsp_bases_per_line   (rsp_bases_per_line),
      .rsp_bytes_per_line   (rsp_bytes_per_line),
      .fail_count           (fail_count),
      .outstanding          (outstanding)
   );

   task automatic send_item(input logic cmd, input logic [7:0] data);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         send_item(fis_pkg::CMD_DATA, s[i]);
   endtask

   task automatic send_line_end(input int term);
      if (term == TERM_CRLF)
         send_item(fis_pkg::CMD_DATA, fis_pkg::CHAR_CR);
      if (term != TERM_NONE)
         send_item(fis_pkg::CMD_DATA, fis_pkg::CHAR_LF);
   endtask

   function automatic int pick_term();
      return ($urandom_range(0, 3) == 0) ? TERM_CRLF : TERM_LF;
   endfunction

   function automatic logic [7:0] any_but_lf();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      return (c == fis_pkg::CHAR_LF) ? 8'hF5 : c;
   endfunction

   task automatic send_bases(input int count);
      int i;
      for (i = 0; i < count; i++)
         send_item(fis_pkg::CMD_DATA, base_chars[$urandom_range(0, 9)]);
   endtask

   task automatic send_header(input bit long_name, input int term);
      int         len;
      int         i;
      logic [7:0] c;
      send_item(fis_pkg::CMD_DATA, fis_pkg::CHAR_GT);
      if (long_name)
         len = $urandom_range(256, 262);
      else if ($urandom_range(0, 79) == 0)
         len = $urandom_range(250, 262);
      else if ($urandom_range(0, 9) == 0)
         len = 0;
      else
         len = $urandom_range(1, 8);
      for (i = 0; i < len; i++) begin
         c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(33, 126));
         if (c == fis_pkg::CHAR_SPACE || c == fis_pkg::CHAR_TAB || c == fis_pkg::CHAR_LF)
            c = 8'h5F;
         send_item(fis_pkg::CMD_DATA, c);
      end
      // optional description after a space or tab
      if ($urandom_range(0, 2) == 0) begin
         send_item(fis_pkg::CMD_DATA,
                   $urandom_range(0, 1) ? fis_pkg::CHAR_SPACE : fis_pkg::CHAR_TAB);
         for (i = $urandom_range(0, 5); i > 0; i--)
            send_item(fis_pkg::CMD_DATA, any_but_lf());
      end
      send_line_end(term);
   endtask

   // blank, cr-led or arbitrary junk line
   task automatic send_noise_line(input int term);
      int i;
      case ($urandom_range(0, 2))
         0: send_item(fis_pkg::CMD_DATA, fis_pkg::CHAR_LF);
         1: begin
            send_item(fis_pkg::CMD_DATA, fis_pkg::CHAR_CR);
            send_bases($urandom_range(0, 6));
            send_line_end(term);
         end
         default: begin
            for (i = $urandom_range(1, 10); i > 0; i--)
               send_item(fis_pkg::CMD_DATA, any_but_lf());
            send_line_end(term);
         end
      endcase
   endtask

   task automatic send_random_file(input bit force_long);
      int entry_total;
      int n_lines;
      int e;
      int k;
      int term;
      bit cut_end;
      bit last_entry;
      req_idle_on = ($urandom_range(0, 3) != 0);
      rsp_idle_on = ($urandom_range(0, 3) != 0);
      cut_end     = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0)
         send_noise_line(pick_term());
      entry_total = $urandom_range(0, 4);
      if (force_long && entry_total == 0)
         entry_total = 1;
      for (e = 0; e < entry_total; e++) begin
         n_lines    = $urandom_range(0, 4);
         last_entry = (e == entry_total - 1);
         send_header(force_long && e == 0,
                     (last_entry && n_lines == 0 && cut_end) ? TERM_NONE : pick_term());
         for (k = 0; k < n_lines; k++) begin
            term = (last_entry && k == n_lines - 1 && cut_end) ? TERM_NONE : pick_term();
            case ($urandom_range(0, 9))
               0: send_noise_line(term);
               1: begin
                  send_bases($urandom_range(40, 90));
                  send_line_end(term);
               end
               default: begin
                  send_bases($urandom_range(1, 14));
                  send_line_end(term);
               end
            endcase
         end
      end
      send_item(fis_pkg::CMD_EOS, 8'($urandom_range(0, 255)));
   endtask

   initial begin : rsp_side
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 3) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int f;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // end of stream with nothing before it
      send_item(fis_pkg::CMD_EOS, 8'h5A);
      // junk line ahead of the first header, with both byte extremes
      send_item(fis_pkg::CMD_DATA, 8'hFF);
      send_item(fis_pkg::CMD_DATA, 8'h00);
      send_item(fis_pkg::CMD_DATA, fis_pkg::CHAR_LF);
      send_text(">ab c\r\n");
      send_text("AC\r\n");
      send_text("\n");
      // empty name gives no record
      send_text(">\n");
      send_text("G\n");
      // header with no sequence lines, then an unterminated header at end of file
      send_text(">q\n");
      send_text(">z");
      send_item(fis_pkg::CMD_EOS, 8'h00);

      items_sent = 0;
      f = 0;
      while (items_sent < ITEM_TARGET) begin
         send_random_file(f == 0);
         f++;
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/fis_pkg.sv
sv/fis_in_stage.sv
sv/fis_core.sv
sv/fasta_index_scanner_unit.sv
tb/fasta_index_scanner_checker.sv
tb/fasta_index_scanner_unit_test.sv
